FILE: rtl/icalc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// icalc_pkg
// Types, character codes and constant tables for the infix calculator.
// ============================================================================
package icalc_pkg;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_FRAC  = 2'd0,
        K_PCT   = 2'd1,
        K_FXMUL = 2'd2,
        K_FXDIV = 2'd3
    } kind_t;

    // start request to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_mul;
        logic fx;      // fixed-point divide: extra fraction steps and rounding
    } md_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } md_stat_t;

    typedef struct packed {
        logic [63:0] sum;
        logic        ovf;
    } sadd_t;

    typedef logic [63:0] p10_tab_t [16];

    function automatic p10_tab_t pow10_table();
        p10_tab_t t;
        t[0] = 64'd1;
        for (int i = 1; i < 16; i++) begin
            t[i] = t[i-1] * 64'd10;
        end
        return t;
    endfunction

    localparam p10_tab_t POW10 = pow10_table();

    function automatic sadd_t sat_add(logic [63:0] a, logic [63:0] b);
        sadd_t       r;
        logic [63:0] s;
        s = a + b;
        r.sum = s;
        r.ovf = 1'b0;
        if (a[63] == b[63] && s[63] != a[63]) begin
            r.ovf = 1'b1;
            r.sum = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

endpackage

FILE: rtl/icalc_muldiv.sv
`timescale 1ns / 1ps
// ============================================================================
// icalc_muldiv
// Bit-serial unsigned multiply / restoring divide with rounding and signed
// saturation of the result.
// ============================================================================
module icalc_muldiv import icalc_pkg::*; #(
    parameter int FRAC_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  md_ctl_t     ctl,
    input  logic [63:0] a_in,     // multiplicand or divisor
    input  logic [63:0] b_in,     // multiplier or dividend
    input  logic        neg_in,
    output md_stat_t    stat,
    output logic [63:0] result
);

    localparam int DIV_FX_ITER = 64 + FRAC_BITS;
    localparam int CNT_W       = $clog2(DIV_FX_ITER);

    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             done_reg, done_next;
    logic             is_mul_reg, is_mul_next;
    logic             fx_reg, fx_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      a_reg, a_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      lo_reg, lo_next;
    logic [63:0]      q_reg, q_next;
    logic             sticky_reg, sticky_next;
    logic [63:0]      res_reg, res_next;
    logic             ovf_reg, ovf_next;

    logic [64:0]  msum;
    logic [64:0]  rem_s;
    logic         ge;
    logic [127:0] prod_r;
    logic [127:0] prod_q;
    logic [64:0]  qsum;
    logic         rnd;
    logic         hi_nz;
    logic [63:0]  mag;

    always_comb begin
        busy_next   = busy_reg;
        fin_next    = 1'b0;
        done_next   = 1'b0;
        is_mul_next = is_mul_reg;
        fx_next     = fx_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        sticky_next = sticky_reg;
        res_next    = res_reg;
        ovf_next    = ovf_reg;

        msum  = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : 65'd0);
        rem_s = {acc_reg, lo_reg[63]};
        ge    = rem_s >= {1'b0, a_reg};

        prod_r = {acc_reg, lo_reg} + (128'd1 << (FRAC_BITS - 1));
        prod_q = prod_r >> FRAC_BITS;
        rnd    = fx_reg && ({acc_reg, 1'b0} >= {1'b0, a_reg});
        qsum   = {1'b0, q_reg} + {64'd0, rnd};

        if (is_mul_reg) begin
            hi_nz = |prod_q[127:64];
            mag   = prod_q[63:0];
        end else begin
            hi_nz = sticky_reg | qsum[64];
            mag   = qsum[63:0];
        end

        if (ctl.start) begin
            busy_next   = 1'b1;
            is_mul_next = ctl.is_mul;
            fx_next     = ctl.fx;
            neg_next    = neg_in;
            a_next      = a_in;
            acc_next    = '0;
            lo_next     = b_in;
            q_next      = '0;
            sticky_next = 1'b0;
            cnt_next    = (!ctl.is_mul && ctl.fx) ? CNT_W'(DIV_FX_ITER - 1) : CNT_W'(63);
        end else if (busy_reg && !fin_reg) begin
            if (is_mul_reg) begin
                acc_next = msum[64:1];
                lo_next  = {msum[0], lo_reg[63:1]};
            end else begin
                acc_next    = ge ? 64'(rem_s - {1'b0, a_reg}) : rem_s[63:0];
                lo_next     = {lo_reg[62:0], 1'b0};
                sticky_next = sticky_reg | q_reg[63];
                q_next      = {q_reg[62:0], ge};
            end
            if (cnt_reg == '0) begin
                fin_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end else if (fin_reg) begin
            // sign and saturation
            busy_next = 1'b0;
            done_next = 1'b1;
            ovf_next  = 1'b0;
            if (neg_reg) begin
                if (hi_nz || mag > SMIN) begin
                    res_next = SMIN;
                    ovf_next = 1'b1;
                end else begin
                    res_next = 64'd0 - mag;
                end
            end else begin
                if (hi_nz || mag > SMAX) begin
                    res_next = SMAX;
                    ovf_next = 1'b1;
                end else begin
                    res_next = mag;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        is_mul_reg <= is_mul_next;
        fx_reg     <= fx_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        a_reg      <= a_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        sticky_reg <= sticky_next;
        res_reg    <= res_next;
        ovf_reg    <= ovf_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign result    = res_reg;

endmodule

FILE: rtl/infix_calculator_evaluator.sv
`timescale 1ns / 1ps
// ============================================================================
// infix_calculator_evaluator
// Two-precedence infix formula evaluator, signed fixed point results.
// ============================================================================
// Input channel (s_valid/s_ready): one formula character per item plus a
// last flag. Result channel (m_valid/m_ready): one item per formula, sent
// after the character flagged last: value, div-by-zero and overflow flags.
// Per input item: '.', integer digits, ignored digits and '+'/'-' ops need no
// arithmetic unit. A fraction digit or '%' runs an integer divide on the shared
// bit-serial multiply/divide unit, one bit a cycle; a pending 'x' runs a
// fixed-point multiply, a pending '/' a divide with FRAC_BITS extra bits. A
// last-flagged item also applies the pending op, then the final sum.
// s_ready is high only while the sequencer is idle. Results sit in an
// output register; the next formula is taken while a result waits, and the
// final sum step holds only if the previous result has not been taken.
// Reset (aresetn low, synchronous) clears the sum, term, typed number,
// flags and pending op (plus) and drops m_valid.
// ============================================================================
module infix_calculator_evaluator import icalc_pkg::*; #(
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_div_by_zero,
    output logic        m_overflow
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_UNIT  = 4'b0010,
        S_APPLY = 4'b0100,
        S_SUM   = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] term_reg, term_next;
    logic        present_reg, present_next;
    logic [63:0] typed_reg, typed_next;
    op_t         pend_reg, pend_next;
    op_t         newop_reg, newop_next;
    kind_t       kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        frac_reg, frac_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic        ovf_reg, ovf_next;
    logic        zdiv_reg, zdiv_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_value_reg, m_value_next;
    logic        m_dz_reg, m_dz_next;
    logic        m_ovf_reg, m_ovf_next;

    md_ctl_t     md_ctl;
    md_stat_t    md_stat;
    logic [63:0] md_a, md_b, md_result;
    logic        md_neg;

    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] d_fix;
    logic [67:0] int_acc;
    logic [64:0] frac_acc;
    logic [63:0] base;
    logic [63:0] push_val;
    sadd_t       push_sum;
    sadd_t       fin_sum;

    icalc_muldiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (md_ctl),
        .a_in    (md_a),
        .b_in    (md_b),
        .neg_in  (md_neg),
        .stat    (md_stat),
        .result  (md_result)
    );

    assign is_digit = (s_char_code >= CH_ZERO) && (s_char_code <= CH_NINE);
    assign digit    = 4'(s_char_code - CH_ZERO);
    assign d_fix    = {60'd0, digit} << FRAC_BITS;
    // typed * 10 + digit, exact; saturates if above the signed max
    assign int_acc  = {1'b0, typed_reg, 3'b000} + {3'b000, typed_reg, 1'b0} + {4'd0, d_fix};
    assign frac_acc = {1'b0, typed_reg} + {1'b0, md_result};
    assign base     = present_reg ? term_reg : 64'd0;
    assign push_val = (pend_reg == OP_MINUS) ? 64'd0 - typed_reg : typed_reg;
    assign push_sum = sat_add(sum_reg, term_reg);
    assign fin_sum  = sat_add(sum_reg, base);

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        present_next = present_reg;
        typed_next   = typed_reg;
        pend_next    = pend_reg;
        newop_next   = newop_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        frac_next    = frac_reg;
        fcnt_next    = fcnt_reg;
        ovf_next     = ovf_reg;
        zdiv_next    = zdiv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_dz_next    = m_dz_reg;
        m_ovf_next   = m_ovf_reg;
        md_ctl       = '0;
        md_a         = '0;
        md_b         = '0;
        md_neg       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next  = s_last_char;
                    state_next = s_last_char ? S_APPLY : S_IDLE;
                    if (s_char_code == CH_DOT) begin
                        frac_next = 1'b1;
                        fcnt_next = '0;
                    end else if (is_digit) begin
                        if (!frac_reg) begin
                            if (int_acc > {4'd0, SMAX}) begin
                                typed_next = SMAX;
                                ovf_next   = 1'b1;
                            end else begin
                                typed_next = int_acc[63:0];
                            end
                        end else if (fcnt_reg < 4'(MAX_FRAC_DIGITS)) begin
                            // part = (d << F + 10^k / 2) / 10^k
                            fcnt_next  = fcnt_reg + 1'b1;
                            md_ctl     = '{start: 1'b1, is_mul: 1'b0, fx: 1'b0};
                            md_a       = POW10[fcnt_reg + 1'b1];
                            md_b       = d_fix + (POW10[fcnt_reg + 1'b1] >> 1);
                            kind_next  = K_FRAC;
                            state_next = S_UNIT;
                        end
                    end else if (s_char_code == CH_PCT) begin
                        md_ctl     = '{start: 1'b1, is_mul: 1'b0, fx: 1'b0};
                        md_a       = 64'd100;
                        md_b       = typed_reg + 64'd50;
                        kind_next  = K_PCT;
                        state_next = S_UNIT;
                    end else if (!s_last_char) begin
                        frac_next  = 1'b0;
                        fcnt_next  = '0;
                        state_next = S_APPLY;
                        case (s_char_code)
                            CH_PLUS:  newop_next = OP_PLUS;
                            CH_MINUS: newop_next = OP_MINUS;
                            CH_TIMES: newop_next = OP_TIMES;
                            default:  newop_next = OP_DIVIDE;
                        endcase
                    end
                end
            end

            S_UNIT: begin
                if (md_stat.done) begin
                    ovf_next = ovf_reg | md_stat.ovf;
                    case (kind_reg)
                        K_FRAC: begin
                            if (frac_acc > {1'b0, SMAX}) begin
                                typed_next = SMAX;
                                ovf_next   = 1'b1;
                            end else begin
                                typed_next = frac_acc[63:0];
                            end
                            state_next = last_reg ? S_APPLY : S_IDLE;
                        end
                        K_PCT: begin
                            typed_next = md_result;
                            state_next = last_reg ? S_APPLY : S_IDLE;
                        end
                        default: begin
                            term_next    = md_result;
                            present_next = 1'b1;
                            typed_next   = '0;
                            pend_next    = newop_reg;
                            state_next   = last_reg ? S_SUM : S_IDLE;
                        end
                    endcase
                end
            end

            S_APPLY: begin
                case (pend_reg)
                    OP_PLUS, OP_MINUS: begin
                        if (present_reg) begin
                            sum_next = push_sum.sum;
                            ovf_next = ovf_reg | push_sum.ovf;
                        end
                        term_next    = push_val;
                        present_next = 1'b1;
                        typed_next   = '0;
                        pend_next    = newop_reg;
                        state_next   = last_reg ? S_SUM : S_IDLE;
                    end
                    OP_TIMES: begin
                        md_ctl     = '{start: 1'b1, is_mul: 1'b1, fx: 1'b1};
                        md_a       = base[63] ? 64'd0 - base : base;
                        md_b       = typed_reg;
                        md_neg     = base[63];
                        kind_next  = K_FXMUL;
                        state_next = S_UNIT;
                    end
                    default: begin
                        if (typed_reg == '0) begin
                            zdiv_next  = 1'b1;
                            pend_next  = newop_reg;
                            state_next = last_reg ? S_SUM : S_IDLE;
                        end else begin
                            md_ctl     = '{start: 1'b1, is_mul: 1'b0, fx: 1'b1};
                            md_a       = typed_reg;
                            md_b       = base[63] ? 64'd0 - base : base;
                            md_neg     = base[63];
                            kind_next  = K_FXDIV;
                            state_next = S_UNIT;
                        end
                    end
                endcase
            end

            S_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = zdiv_reg ? 64'd0 : fin_sum.sum;
                    m_dz_next    = zdiv_reg;
                    m_ovf_next   = ovf_reg | fin_sum.ovf;
                    sum_next     = '0;
                    term_next    = '0;
                    present_next = 1'b0;
                    typed_next   = '0;
                    pend_next    = OP_PLUS;
                    frac_next    = 1'b0;
                    fcnt_next    = '0;
                    ovf_next     = 1'b0;
                    zdiv_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            term_reg    <= '0;
            present_reg <= 1'b0;
            typed_reg   <= '0;
            pend_reg    <= OP_PLUS;
            frac_reg    <= 1'b0;
            fcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            zdiv_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            present_reg <= present_next;
            typed_reg   <= typed_next;
            pend_reg    <= pend_next;
            frac_reg    <= frac_next;
            fcnt_reg    <= fcnt_next;
            ovf_reg     <= ovf_next;
            zdiv_reg    <= zdiv_next;
            m_valid_reg <= m_valid_next;
        end
        newop_reg   <= newop_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        m_value_reg <= m_value_next;
        m_dz_reg    <= m_dz_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_div_by_zero = m_dz_reg;
    assign m_overflow    = m_ovf_reg;

    // unit must be quiet whenever new characters are taken
    a_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !md_stat.busy)
        else $error("muldiv busy while idle");

    a_done_in_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.done |-> (state_reg == S_UNIT))
        else $error("muldiv done outside wait state");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dz_reg) |-> (m_value_reg == '0))
        else $error("div-by-zero result not zero");

    a_fcnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= 4'(MAX_FRAC_DIGITS))
        else $error("fraction digit count over limit");

endmodule

FILE: tb/infix_calculator_evaluator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// infix_calculator_evaluator_tb
// Self-checking bench for the two-precedence fixed-point formula evaluator.
// ============================================================================
// Formulas go in one character per item, either as a few hand-picked cases or
// as random well-formed formulas mixed with noise. A scoreboard class tracks
// the evaluator state, predicts each result and compares it field by field.
// Both handshake sides stall at random.
// ============================================================================
module infix_calculator_evaluator_tb;
    import icalc_pkg::*;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam int         IDLE_LIMIT = 3000;

    // one expected formula result
    typedef struct {
        logic [63:0] value;
        logic        dz;
        logic        ovf;
    } calc_result_t;

    int errors = 0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the evaluator state and a queue of results
    // ------------------------------------------------------------------------
    class formula_scoreboard;
        logic [63:0]  sum_acc, term, typed;
        logic         have_term, frac_mode, ovf_flag, dz_flag;
        int unsigned  frac_cnt;
        op_t          op_pend;
        calc_result_t awaited[$];

        function new();
            clear();
        endfunction

        function void clear();
            sum_acc = '0; term = '0; typed = '0; have_term = 0;
            frac_mode = 0; frac_cnt = 0; ovf_flag = 0; dz_flag = 0;
            op_pend = OP_PLUS;
        endfunction

        // signed result from sign and magnitude, saturating
        function logic [63:0] signed_of(logic neg, logic [127:0] m);
            if (neg) begin
                if (m > {64'd0, SMIN}) begin
                    ovf_flag = 1;
                    return SMIN;
                end
                return -m[63:0];
            end
            if (m > {64'd0, SMAX}) begin
                ovf_flag = 1;
                return SMAX;
            end
            return m[63:0];
        endfunction

        function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) begin
                ovf_flag = 1;
                return a[63] ? SMIN : SMAX;
            end
            return s;
        endfunction

        function logic [63:0] magn(logic [63:0] v);
            return v[63] ? -v : v;
        endfunction

        // product rounded half away from zero
        function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, magn(a)} * {64'd0, magn(b)};
            p = (p + (128'd1 << 31)) >> 32;
            return signed_of(a[63] ^ b[63], p);
        endfunction

        function logic [63:0] div_q(logic [63:0] a, logic [63:0] b);
            logic [127:0] num, den, q, r;
            num = {64'd0, magn(a)} << 32;
            den = {64'd0, magn(b)};
            q = num / den;
            r = num % den;
            if (r >= den - r) q = q + 1;
            return signed_of(a[63] ^ b[63], q);
        endfunction

        function void digit_in(logic [63:0] d);
            logic [63:0] add, p, part;
            if (!frac_mode) begin
                add = d << 32;
                if (typed > (SMAX - add) / 10) begin
                    typed = SMAX;
                    ovf_flag = 1;
                end else begin
                    typed = typed * 10 + add;
                end
            end else if (frac_cnt < 9) begin
                frac_cnt++;
                p = 1;
                for (int i = 0; i < frac_cnt; i++) p = p * 10;
                part = ((d << 32) + p / 2) / p;
                if (typed > SMAX - part) begin
                    typed = SMAX;
                    ovf_flag = 1;
                end else begin
                    typed = typed + part;
                end
            end
        endfunction

        function void push_term(logic [63:0] v);
            if (have_term) sum_acc = add_sat(sum_acc, term);
            term = v;
            have_term = 1;
        endfunction

        function void fold_pending();
            logic [63:0] base;
            base = have_term ? term : '0;
            case (op_pend)
                OP_PLUS:  push_term(typed);
                OP_MINUS: push_term(-typed);
                OP_TIMES: begin
                    term = mul_q(base, typed);
                    have_term = 1;
                end
                default: begin
                    if (typed == 0) begin
                        dz_flag = 1;
                    end else begin
                        term = div_q(base, typed);
                        have_term = 1;
                    end
                end
            endcase
            typed = '0;
        endfunction

        // an accepted input item
        function void note_char(logic [7:0] c, logic last);
            calc_result_t r;
            logic [63:0]  total;
            if (c == CH_DOT) begin
                frac_mode = 1;
                frac_cnt = 0;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                digit_in(64'(c - CH_ZERO));
            end else if (c == CH_PCT) begin
                typed = (typed + 50) / 100;
            end else if (!last) begin
                frac_mode = 0;
                frac_cnt = 0;
                fold_pending();
                op_pend = (c == CH_PLUS) ? OP_PLUS : (c == CH_MINUS) ? OP_MINUS :
                          (c == CH_TIMES) ? OP_TIMES : OP_DIVIDE;
            end
            if (last) begin
                fold_pending();
                total = add_sat(sum_acc, have_term ? term : 64'd0);
                r.value = dz_flag ? 64'd0 : total;
                r.dz = dz_flag;
                r.ovf = ovf_flag;
                awaited = {awaited, r};
                clear();
            end
        endfunction

        // an accepted result item
        task check_result(logic [63:0] v, logic dz, logic ovf);
            calc_result_t e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result value=%h", v));
                return;
            end
            e = awaited.pop_front();
            if (v !== e.value)
                report($sformatf("value %h, expected %h", v, e.value));
            if (dz !== e.dz)
                report($sformatf("div_by_zero %b, expected %b", dz, e.dz));
            if (ovf !== e.ovf)
                report($sformatf("overflow %b, expected %b", ovf, e.ovf));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        s_last_char = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_value;
    logic        m_div_by_zero;
    logic        m_overflow;

    formula_scoreboard sb = new();
    int  chars_sent = 0;
    int  idle_cycles = 0;
    bit  no_stall = 0;     // stretches with both sides running flat out

    infix_calculator_evaluator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_char_code(s_char_code), .s_last_char(s_last_char),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_div_by_zero(m_div_by_zero), .m_overflow(m_overflow)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Result side: check on handshake, samples are pre-edge values.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value, m_div_by_zero, m_overflow);
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall before each result; no double assignment per step.
    initial begin : sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_stall ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // One character item; valid stays high across back-to-back items.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1;
        s_char_code <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Random well-formed formula; the final character is drawn at random.
    task automatic send_random_formula();
        logic [7:0] q[$];
        int terms, n;
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: q = {q, CH_PLUS};
                    3, 4:    q = {q, CH_MINUS};
                    5, 6:    q = {q, CH_TIMES};
                    7, 8:    q = {q, CH_SLASH};
                    default: q = {q, 8'($urandom_range(0, 255))};
                endcase
            end
            // mostly short numbers, now and then enough digits to saturate
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) q = {q, CH_ZERO + 8'($urandom_range(0, 9))};
            if ($urandom_range(0, 2) == 0) begin
                q = {q, CH_DOT};
                n = $urandom_range(0, 11);
                for (int i = 0; i < n; i++) q = {q, CH_ZERO + 8'($urandom_range(0, 9))};
                if ($urandom_range(0, 9) == 0) q = {q, CH_DOT};
            end
            if ($urandom_range(0, 7) == 0) q = {q, CH_PCT};
        end
        case ($urandom_range(0, 3))
            0:       q = {q, CH_ZERO + 8'($urandom_range(0, 9))};
            1:       q = {q, CH_PLUS};
            2:       q = {q, CH_PCT};
            default: q = {q, 8'($urandom_range(0, 255))};
        endcase
        foreach (q[i]) send_char(q[i], i == q.size() - 1);
    endtask

    // Pure noise: arbitrary bytes, last mark on the final one.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    initial begin : stim
        int formulas;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: precedence, leading x and /, divide by zero, repeated dot,
        // excess fraction digits, operator as last char, unknown char,
        // integer and product saturation, percent
        send_text("12.5x3-4/8");
        send_text("x5+1");
        send_text("/2-3");
        send_text("9/0+1");
        send_text("1.2.3%");
        send_text("0.1234567891234");
        send_text("3x2+");
        send_text("5q2");
        send_text("99999999999x1");
        send_text("2000000000x2000000000");

        formulas = 0;
        while (chars_sent < 1300) begin
            if (formulas % 40 == 0) no_stall = ($urandom_range(0, 3) == 0);
            if (formulas == 60) begin
                // drain everything before carrying on
                s_valid <= 0;
                @(posedge aclk);
                while (sb.awaited.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_formula();
            formulas++;
        end
        s_valid <= 0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/icalc_pkg.sv
rtl/icalc_muldiv.sv
rtl/infix_calculator_evaluator.sv
tb/infix_calculator_evaluator_tb.sv
